FILE: sv/otr_pkg.sv
`timescale 1ns / 1ps

package otr_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned THR_W  = 7;
  localparam int unsigned TRIG_W = 64;
  localparam int unsigned RUN_W  = 32;
  localparam int unsigned KIND_W = 64;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_DATA_W  = TRIG_W + RUN_W + KIND_W + TS_W;
  localparam int unsigned OUT_DATA_W = 1 + THR_W + TRIG_W + RUN_W + KIND_W + TS_W;

  localparam logic [THR_W-1:0] THR_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_FLUSH    = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_FOUND   = 2'd1,
    STAT_FULL        = 2'd2,
    STAT_FLUSH_EMPTY = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_BUSY_THR = 1'b0,
    REG_FREE_THR = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SHIFT,
    S_FL_RD,
    S_FL_WT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [TS_W-1:0]   ts;
    logic [KIND_W-1:0] kind;
    logic [RUN_W-1:0]  run;
    logic [TRIG_W-1:0] trig;
  } entry_t;

endpackage

FILE: sv/outstanding_assignment_tracker.sv
`timescale 1ns / 1ps

// Outstanding assignment tracker: an insertion-ordered table of up to CAPACITY
// assignments held in one synchronous entry memory (one write and one read port,
// registered read data). One transaction is worked at a time. An add writes
// the entry on acceptance unless the table is full, then responds. A lookup
// walks the table one entry per cycle from the oldest until a match or the end
// of the occupancy. A complete adds the compaction pass that moves every younger
// entry down one slot, again one entry per cycle. A flush empties the table at
// once and then emits one result per entry, reading, capturing and sending each
// in turn. Only the response state waits on the result side, which can stall
// it. Entries are undefined after reset and only ever read below the occupancy,
// so no clearing pass is needed; thresholds are to be written on the cfg port
// while the block is idle, which the block does not enforce.
module outstanding_assignment_tracker #(
  parameter int unsigned CAPACITY = otr_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_addr_i,
  input  logic [otr_pkg::THR_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // trigger_id, run_id, trigger_kind, now_us
  input  logic [otr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // opcode
  input  logic [otr_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // busy_res, occupancy, found_trigger, found_run, found_kind, elapsed_us
  output logic [otr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [otr_pkg::STAT_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import otr_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = (CNT_W > THR_W) ? CNT_W : THR_W;

  // entry memory
  entry_t          mem_q [CAPACITY];
  entry_t          rdata_q;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_wdata;

  state_e          state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic            busy_q, busy_d;
  logic [THR_W-1:0] busy_thr_q, free_thr_q;
  opcode_e         op_q, op_d;
  logic [TRIG_W-1:0] key_q, key_d;
  logic [TS_W-1:0] now_q, now_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic            rv_q, rv_d;
  logic [CNT_W-1:0] ri_q, ri_d;
  logic [CNT_W-1:0] fl_n_q, fl_n_d;
  status_e         stat_q, stat_d;
  logic [TRIG_W-1:0] res_trig_q, res_trig_d;
  logic [RUN_W-1:0] res_run_q, res_run_d;
  logic [KIND_W-1:0] res_kind_q, res_kind_d;
  logic [TS_W-1:0] res_el_q, res_el_d;
  logic            last_q, last_d;
  logic            m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [STAT_W-1:0] m_user_q, m_user_d;
  logic            m_last_q, m_last_d;

  logic            in_acc;
  logic            out_free;
  opcode_e         in_op;
  entry_t          in_ent;
  logic            hit;
  logic            srch_miss;
  logic            shift_done;
  logic            rd_more;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] ri_dec;
  logic [CNT_W-1:0] ptr_inc;
  logic [CW-1:0]   occ_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign in_op         = opcode_e'(s_axis_tuser);
  assign in_ent        = entry_t'(s_axis_tdata);

  assign cnt_inc = count_q + CNT_W'(1);
  assign cnt_dec = count_q - CNT_W'(1);
  assign ri_dec  = ri_q - CNT_W'(1);
  assign ptr_inc = ptr_q + CNT_W'(1);
  assign occ_ext = CW'(count_q);
  assign rd_more = (ptr_q < count_q);

  assign hit        = (state_q == S_SRCH) && rv_q && (rdata_q.trig == key_q);
  assign srch_miss  = (state_q == S_SRCH) && !rv_q && !rd_more;
  assign shift_done = (state_q == S_SHIFT) && !rv_q && !rd_more;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD:   state_d = S_RESP;
            OP_FLUSH: state_d = (count_q == '0) ? S_RESP : S_FL_RD;
            default:  state_d = S_SRCH;
          endcase
        end
      end
      S_SRCH: begin
        if (hit) begin
          state_d = (op_q == OP_COMPLETE) ? S_SHIFT : S_RESP;
        end else if (srch_miss) begin
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_RESP;
        end
      end
      S_FL_RD: state_d = S_FL_WT;
      S_FL_WT: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = (op_q == OP_FLUSH && !last_q) ? S_FL_RD : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d    = count_q;
    busy_d     = busy_q;
    op_d       = op_q;
    key_d      = key_q;
    now_d      = now_q;
    ptr_d      = ptr_q;
    rv_d       = rv_q;
    ri_d       = ri_q;
    fl_n_d     = fl_n_q;
    stat_d     = stat_q;
    res_trig_d = res_trig_q;
    res_run_d  = res_run_q;
    res_kind_d = res_kind_q;
    res_el_d   = res_el_q;
    last_d     = last_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_last_d   = m_last_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = count_q[AW-1:0];
    mem_raddr  = ptr_q[AW-1:0];
    mem_wdata  = in_ent;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = in_op;
          key_d      = in_ent.trig;
          now_d      = in_ent.ts;
          ptr_d      = '0;
          rv_d       = 1'b0;
          stat_d     = STAT_OK;
          res_trig_d = '0;
          res_run_d  = '0;
          res_kind_d = '0;
          res_el_d   = '0;
          last_d     = 1'b1;
          case (in_op)
            OP_ADD: begin
              if (count_q >= CNT_W'(CAPACITY)) begin
                stat_d = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = cnt_inc;
                if (CW'(cnt_inc) >= CW'(busy_thr_q)) begin
                  busy_d = 1'b1;
                end
              end
            end
            OP_FLUSH: begin
              fl_n_d  = count_q;
              count_d = '0;
              busy_d  = 1'b0;
              if (count_q == '0) begin
                stat_d = STAT_FLUSH_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH: begin
        rv_d = 1'b0;
        if (hit) begin
          res_trig_d = rdata_q.trig;
          res_run_d  = rdata_q.run;
          res_kind_d = rdata_q.kind;
          res_el_d   = now_q - rdata_q.ts;
          ptr_d      = ri_q + CNT_W'(1);
        end else begin
          if (rd_more) begin
            mem_re = 1'b1;
            ptr_d  = ptr_inc;
            rv_d   = 1'b1;
            ri_d   = ptr_q;
          end
          if (srch_miss) begin
            stat_d = STAT_NOT_FOUND;
            if (op_q == OP_COMPLETE && occ_ext < CW'(free_thr_q)) begin
              busy_d = 1'b0;
            end
          end
        end
      end
      S_SHIFT: begin
        rv_d = 1'b0;
        if (rd_more) begin
          mem_re = 1'b1;
          ptr_d  = ptr_inc;
          rv_d   = 1'b1;
          ri_d   = ptr_q;
        end
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = ri_dec[AW-1:0];
          mem_wdata = rdata_q;
        end
        if (shift_done) begin
          count_d = cnt_dec;
          if (CW'(cnt_dec) < CW'(free_thr_q)) begin
            busy_d = 1'b0;
          end
        end
      end
      S_FL_RD: begin
        mem_re = 1'b1;
      end
      S_FL_WT: begin
        stat_d     = STAT_OK;
        res_trig_d = rdata_q.trig;
        res_run_d  = rdata_q.run;
        res_kind_d = rdata_q.kind;
        res_el_d   = now_q - rdata_q.ts;
        last_d     = (ptr_inc == fl_n_q);
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_el_q, res_kind_q, res_run_q, res_trig_q, occ_ext[THR_W-1:0], busy_q};
          m_user_d  = stat_q;
          m_last_d  = last_q;
          if (op_q == OP_FLUSH && !last_q) begin
            ptr_d = ptr_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      busy_q     <= 1'b0;
      busy_thr_q <= THR_RESET;
      free_thr_q <= THR_RESET;
      op_q       <= OP_ADD;
      ptr_q      <= '0;
      rv_q       <= 1'b0;
      ri_q       <= '0;
      fl_n_q     <= '0;
      last_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      busy_q    <= busy_d;
      op_q      <= op_d;
      ptr_q     <= ptr_d;
      rv_q      <= rv_d;
      ri_q      <= ri_d;
      fl_n_q    <= fl_n_d;
      last_q    <= last_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_BUSY_THR: busy_thr_q <= cfg_wdata_i;
          REG_FREE_THR: free_thr_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    now_q      <= now_d;
    stat_q     <= stat_d;
    res_trig_q <= res_trig_d;
    res_run_q  <= res_run_d;
    res_kind_q <= res_kind_d;
    res_el_q   <= res_el_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
    m_last_q   <= m_last_d;
  end

endmodule

FILE: sv/otr_checker.sv
`timescale 1ns / 1ps

module otr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [otr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [otr_pkg::STAT_W-1:0]      m_axis_tuser,
  input logic                            m_axis_tlast
);
  import otr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // one transaction at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while working");

  // a miss returns no entry
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_NOT_FOUND |->
      m_axis_tdata[OUT_DATA_W-1:THR_W+1] == '0)
    else $error("miss with entry data");

  // non-final flush results and an empty flush's result show an emptied, idle table
  a_flush_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (!m_axis_tlast || m_axis_tuser == STAT_FLUSH_EMPTY) |->
      m_axis_tdata[THR_W:0] == '0)
    else $error("flush result with busy or occupancy");

endmodule

bind outstanding_assignment_tracker otr_checker u_otr_checker (.*);
